>>> src/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg
// shared types and constants of the midpoint ellipse rasterizer
// ----------------------------------------------------------------------------
package mer_pkg;

	// radius saturation limit
	localparam int MAX_RADIUS = 31;

	// last point index allowed within one ellipse (64 points)
	localparam logic [5:0] CNT_LAST = 6'd63;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_INIT,
		ST_REGION1,
		ST_PREP_A,
		ST_PREP_B,
		ST_PREP_C,
		ST_PREP_D,
		ST_REGION2
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQUARE,
		OP_INIT,
		OP_STEP1,
		OP_PREP_A,
		OP_PREP_B,
		OP_PREP_C,
		OP_PREP_D,
		OP_STEP2
	} op_t;

	// controller to datapath
	typedef struct packed {
		op_t  op;
		logic emit;
		logic last;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic r1_go;     // step_x < step_y
		logic y_zero;    // current y offset is zero
		logic cnt_last;  // this point is the 64th
		logic out_busy;  // output register holds an untaken beat
	} stat_t;

endpackage

>>> src/mer_ctrl.sv
// ----------------------------------------------------------------------------
// mer_ctrl
// sequencer for setup, region one, region two setup and region two
// ----------------------------------------------------------------------------
module mer_ctrl
	import mer_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output logic  idle,
	output ctrl_t ctrl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SQUARE;
			end
			ST_SQUARE: state_d = ST_INIT;
			ST_INIT:   state_d = ST_REGION1;
			ST_REGION1: begin
				if (!stat.r1_go) begin
					state_d = ST_PREP_A;
				end else if (!stat.out_busy && stat.cnt_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_PREP_A: state_d = ST_PREP_B;
			ST_PREP_B: state_d = ST_PREP_C;
			ST_PREP_C: state_d = ST_PREP_D;
			ST_PREP_D: state_d = ST_REGION2;
			ST_REGION2: begin
				if (!stat.out_busy && (stat.cnt_last || stat.y_zero)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl.op   = OP_NONE;
		ctrl.emit = 1'b0;
		ctrl.last = 1'b0;
		idle      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) ctrl.op = OP_LOAD;
			end
			ST_SQUARE: ctrl.op = OP_SQUARE;
			ST_INIT:   ctrl.op = OP_INIT;
			ST_REGION1: begin
				if (stat.r1_go && !stat.out_busy) begin
					ctrl.op   = OP_STEP1;
					ctrl.emit = 1'b1;
					ctrl.last = stat.cnt_last;
				end
			end
			ST_PREP_A: ctrl.op = OP_PREP_A;
			ST_PREP_B: ctrl.op = OP_PREP_B;
			ST_PREP_C: ctrl.op = OP_PREP_C;
			ST_PREP_D: ctrl.op = OP_PREP_D;
			ST_REGION2: begin
				if (!stat.out_busy) begin
					ctrl.op   = OP_STEP2;
					ctrl.emit = 1'b1;
					ctrl.last = stat.cnt_last || stat.y_zero;
				end
			end
			default: ctrl.op = OP_NONE;
		endcase
	end

	// a point is never issued over an untaken beat
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> !stat.out_busy)
		else $error("point issued while output register busy");

	// an accepted ellipse always starts with the squaring step
	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> state_q == ST_SQUARE)
		else $error("accepted ellipse did not enter setup");

	// the last beat of an ellipse returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && ctrl.last) |=> state_q == ST_IDLE)
		else $error("sequencer kept running after last point");

	// region two setup always runs its four steps in order
	a_prep_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PREP_A |=> state_q == ST_PREP_B ##1 state_q == ST_PREP_C
			##1 state_q == ST_PREP_D ##1 state_q == ST_REGION2)
		else $error("region two setup out of order");

endmodule

>>> src/mer_datapath.sv
// ----------------------------------------------------------------------------
// mer_datapath
// decision variable arithmetic, offsets and the output register
// ----------------------------------------------------------------------------
module mer_datapath
	import mer_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	input  logic signed [6:0] center_x,
	input  logic signed [6:0] center_y,
	input  logic [4:0]        radius_x,
	input  logic [4:0]        radius_y,
	input  logic [7:0]        symbol,
	input  logic              out_ready,
	output stat_t             stat,
	output logic              out_valid,
	output logic [7:0]        x_right,
	output logic [7:0]        x_left,
	output logic [7:0]        y_upper,
	output logic [7:0]        y_lower,
	output logic [7:0]        glyph,
	output logic              last
);

	// ellipse parameters
	logic signed [6:0]  cx_q, cy_q;
	logic [4:0]         rx_q, ry_q;
	logic [7:0]         sym_q;
	logic [9:0]         rx2_q, ry2_q;

	// iteration state
	logic [6:0]         x_q;
	logic signed [6:0]  y_q;
	logic signed [23:0] sx_q, sy_q;
	logic signed [31:0] d_q;
	logic [5:0]         cnt_q;

	// region two setup temporaries
	logic [13:0]        t1_q;
	logic [9:0]         t2_q;
	logic [23:0]        t3_q;
	logic [19:0]        t4_q, t5_q;

	// output register
	logic               ov_q;
	logic [7:0]         xr_q, xl_q, yu_q, yl_q, gl_q;
	logic               last_q;

	logic signed [23:0] two_rx2, two_ry2, sx_n, sy_n;
	logic signed [31:0] rx2_x4, ry2_x4, sx_n_x4, sy_n_x4;
	logic [14:0]        prod_rxy;
	logic [7:0]         hx;
	logic signed [6:0]  ym;
	logic signed [13:0] ym_sq;
	logic [15:0]        hx_sq;
	logic [8:0]         xr_w, xl_w, yu_w, yl_w;

	assign two_rx2  = $signed({13'd0, rx2_q, 1'b0});
	assign two_ry2  = $signed({13'd0, ry2_q, 1'b0});
	assign sx_n     = sx_q + two_ry2;
	assign sy_n     = sy_q - two_rx2;
	assign rx2_x4   = $signed({20'd0, rx2_q, 2'b00});
	assign ry2_x4   = $signed({20'd0, ry2_q, 2'b00});
	assign sx_n_x4  = $signed({{6{sx_n[23]}}, sx_n, 2'b00});
	assign sy_n_x4  = $signed({{6{sy_n[23]}}, sy_n, 2'b00});
	assign prod_rxy = {5'd0, rx2_q} * {10'd0, ry_q};
	assign hx       = {x_q, 1'b1};
	assign hx_sq    = {8'd0, hx} * {8'd0, hx};
	assign ym       = y_q - 7'sd1;
	assign ym_sq    = $signed({{7{ym[6]}}, ym}) * $signed({{7{ym[6]}}, ym});

	// mirrored coordinates, wrapped to eight bits
	assign xr_w = {{2{cx_q[6]}}, cx_q} + {2'b00, x_q};
	assign xl_w = {{2{cx_q[6]}}, cx_q} - {2'b00, x_q};
	assign yu_w = {{2{cy_q[6]}}, cy_q} + {{2{y_q[6]}}, y_q};
	assign yl_w = {{2{cy_q[6]}}, cy_q} - {{2{y_q[6]}}, y_q};

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				cx_q  <= center_x;
				cy_q  <= center_y;
				rx_q  <= (int'(radius_x) > MAX_RADIUS) ? 5'(MAX_RADIUS) : radius_x;
				ry_q  <= (int'(radius_y) > MAX_RADIUS) ? 5'(MAX_RADIUS) : radius_y;
				sym_q <= symbol;
				cnt_q <= '0;
			end
			OP_SQUARE: begin
				rx2_q <= {5'd0, rx_q} * {5'd0, rx_q};
				ry2_q <= {5'd0, ry_q} * {5'd0, ry_q};
			end
			OP_INIT: begin
				x_q  <= '0;
				y_q  <= $signed({2'b00, ry_q});
				sx_q <= '0;
				sy_q <= $signed({8'd0, prod_rxy, 1'b0});
				d_q  <= ry2_x4 - $signed({15'd0, prod_rxy, 2'b00})
					+ $signed({22'd0, rx2_q});
			end
			OP_STEP1: begin
				cnt_q <= cnt_q + 6'd1;
				x_q   <= x_q + 7'd1;
				sx_q  <= sx_n;
				if (d_q < 0) begin
					d_q <= d_q + sx_n_x4 + ry2_x4;
				end else begin
					y_q  <= y_q - 7'sd1;
					sy_q <= sy_n;
					d_q  <= d_q + sx_n_x4 - sy_n_x4 + ry2_x4;
				end
			end
			OP_PREP_A: begin
				t1_q <= hx_sq[13:0];
				t2_q <= ym_sq[9:0];
			end
			OP_PREP_B: begin
				t3_q <= {14'd0, ry2_q} * {10'd0, t1_q};
				t4_q <= {10'd0, rx2_q} * {10'd0, t2_q};
			end
			OP_PREP_C: begin
				t5_q <= {10'd0, rx2_q} * {10'd0, ry2_q};
			end
			OP_PREP_D: begin
				d_q <= $signed({8'd0, t3_q}) + $signed({10'd0, t4_q, 2'b00})
					- $signed({10'd0, t5_q, 2'b00});
			end
			OP_STEP2: begin
				cnt_q <= cnt_q + 6'd1;
				y_q   <= y_q - 7'sd1;
				sy_q  <= sy_n;
				if (d_q > 0) begin
					d_q <= d_q + rx2_x4 - sy_n_x4;
				end else begin
					x_q  <= x_q + 7'd1;
					sx_q <= sx_n;
					d_q  <= d_q + sx_n_x4 - sy_n_x4 + rx2_x4;
				end
			end
			default: begin
			end
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			xr_q   <= xr_w[7:0];
			xl_q   <= xl_w[7:0];
			yu_q   <= yu_w[7:0];
			yl_q   <= yl_w[7:0];
			gl_q   <= sym_q;
			last_q <= ctrl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ctrl.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	assign stat.r1_go    = sx_q < sy_q;
	assign stat.y_zero   = (y_q == 7'sd0);
	assign stat.cnt_last = (cnt_q == CNT_LAST);
	assign stat.out_busy = ov_q && !out_ready;

	assign out_valid = ov_q;
	assign x_right   = xr_q;
	assign x_left    = xl_q;
	assign y_upper   = yu_q;
	assign y_lower   = yl_q;
	assign glyph     = gl_q;
	assign last      = last_q;

endmodule

>>> src/midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// two-region midpoint ellipse walker emitting four-way mirrored point sets
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one beat per ellipse (center, radii, symbol). s_tready is high
//   only while the sequencer is idle, so one ellipse is walked at a time.
//   m_* channel: one beat per point set: both mirrored x coordinates, both
//   mirrored y coordinates and the symbol; m_tlast marks the final point set.
// sequence
//   after the accepting edge, the square and init states square the radii and
//   form the first decision value; each region one step then registers a beat.
//   once region one ends, 4 steps (prep a to prep d) form the region two decision
//   value, and each other cycle emits one beat while the output register is not
//   busy. an ellipse gives n point sets (n <= 64, about radius_x + radius_y + 1);
//   the walk sets the rate.
// stall
//   a single output register parts the walk from the receiver; while it holds
//   an untaken beat the walk freezes and resumes the cycle it is taken.
// reset
//   arst_n clears the sequencer to idle and drops m_tvalid; nothing else needs
//   clearing since every ellipse reloads its own state.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer
	import mer_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// ellipse beat
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // center_x[6:0], center_y[13:7], radius_x[18:14],
	                               // radius_y[23:19], symbol[31:24]
	// point set beat
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // x_right[7:0], x_left[15:8], y_upper[23:16],
	                               // y_lower[31:24], glyph[39:32]
	output logic        m_tlast    // last point set of the ellipse
);

	ctrl_t ctrl;
	stat_t stat;
	logic  idle;
	logic  accept;

	logic [7:0] x_right, x_left, y_upper, y_lower, glyph;

	// handshake: a beat is taken only while the sequencer idles
	assign s_tready = idle;
	assign accept   = s_tvalid && idle;

	mer_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.stat   (stat),
		.idle   (idle),
		.ctrl   (ctrl)
	);

	// unpack the ellipse beat straight into the datapath
	mer_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.center_x  ($signed(s_tdata[6:0])),
		.center_y  ($signed(s_tdata[13:7])),
		.radius_x  (s_tdata[18:14]),
		.radius_y  (s_tdata[23:19]),
		.symbol    (s_tdata[31:24]),
		.out_ready (m_tready),
		.stat      (stat),
		.out_valid (m_tvalid),
		.x_right   (x_right),
		.x_left    (x_left),
		.y_upper   (y_upper),
		.y_lower   (y_lower),
		.glyph     (glyph),
		.last      (m_tlast)
	);

	// pack the point set beat, first field lowest
	assign m_tdata = {glyph, y_lower, y_upper, x_left, x_right};

endmodule
